// ===== rtl/core/mbp_pkg.sv =====
// mbp_pkg: shared constants and types for the msb-first bit packer
// no dependencies; imported by every module of the block
`default_nettype none

package mbp_pkg;

  // word and field sizes
  localparam int WORD_BITS_DEFAULT = 32;
  localparam int VALUE_BITS        = 32;
  localparam int WIDTH_BITS        = 6;
  localparam int BYTE_BITS         = 8;

  // input tdata: value in the low bits, then width, padded to whole bytes
  localparam int S_TDATA_BITS = ((VALUE_BITS + WIDTH_BITS + 7) / 8) * 8;

  // depth of the word queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mbp_front.sv =====
// mbp_front: takes requests, appends fields to the accumulator, pushes full words
// depends on mbp_pkg; feeds mbp_queue
`default_nettype none

module mbp_front
  import mbp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic [WIDTH_BITS-1:0] in_width,
  input  wire q_status_t             q_status,
  output logic                       push,
  output logic [WORD_BITS-1:0]       push_word
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic [WORD_BITS-1:0] accumulator;
  logic [CW-1:0]        bits_used;

  logic [WORD_BITS-1:0] accumulator_next;
  logic [CW-1:0]        bits_used_next;
  logic [CW-1:0]        n;
  logic [CW-1:0]        free_bits;
  logic [CW-1:0]        rest;
  logic                 fits;
  logic                 accept;
  logic [WORD_BITS-1:0] x_w;
  logic [WORD_BITS-1:0] x_hi_w;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // field width saturated to the word size, free room and overflow count
  always_comb begin
    if (8'(in_width) > 8'(WORD_BITS)) begin
      n = CW'(WORD_BITS);
    end else begin
      n = CW'(in_width);
    end
    free_bits = CW'(WORD_BITS) - bits_used;
    fits      = (n <= free_bits);
    rest      = n - free_bits;
  end

  // value resized to the word, and its leading bits for the top-up
  assign x_w    = WORD_BITS'(in_value);
  assign x_hi_w = WORD_BITS'(in_value >> rest);

  // next accumulator state and the word that leaves on overflow
  always_comb begin
    push_word = (accumulator << free_bits)
              | (x_hi_w & ~({WORD_BITS{1'b1}} << free_bits));
    if (fits) begin
      accumulator_next = (accumulator << n) | (x_w & ~({WORD_BITS{1'b1}} << n));
      bits_used_next   = bits_used + n;
    end else begin
      accumulator_next = x_w & ~({WORD_BITS{1'b1}} << rest);
      bits_used_next   = rest;
    end
  end

  assign push = accept && !fits;

  // accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      bits_used   <= '0;
    end else if (accept) begin
      accumulator <= accumulator_next;
      bits_used   <= bits_used_next;
    end
  end

  // bit count never passes the word size
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    bits_used <= CW'(WORD_BITS))
    else $error("bits_used beyond word size");

  // a word leaves only when the field overflows the free room
  a_push_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (n > free_bits) && (n != '0))
    else $error("word pushed without overflow");

endmodule

`default_nettype wire

// ===== rtl/core/mbp_queue.sv =====
// mbp_queue: short word queue between front and back
// depends on mbp_pkg
`default_nettype none

module mbp_queue
  import mbp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [WORD_BITS-1:0] push_word,
  input  wire logic                 pop,
  output logic [WORD_BITS-1:0]      pop_word,
  output q_status_t                 status
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WORD_BITS-1:0] entries [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [NW-1:0]        count;

  assign status.full  = (count == NW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_word     = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // no write into a full queue, no read from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && status.empty))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/mbp_back.sv =====
// mbp_back: splits queued words into bytes, high byte first, with an output register
// depends on mbp_pkg; reads from mbp_queue
`default_nettype none

module mbp_back
  import mbp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire q_status_t            q_status,
  input  wire logic [WORD_BITS-1:0] q_word,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [BYTE_BITS-1:0]      out_byte,
  output logic                      out_last
);

  localparam int WORD_BYTES = (WORD_BITS + BYTE_BITS - 1) / BYTE_BITS;
  localparam int PB         = WORD_BYTES * BYTE_BITS;
  localparam int BIW        = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

  logic          active;
  logic [PB-1:0] shreg;
  logic [BIW-1:0] byte_idx;
  logic          load;
  logic          is_last;

  assign is_last = (byte_idx == BIW'(WORD_BYTES - 1));
  assign load    = active && (!out_valid || out_ready);
  assign pop     = !q_status.empty && (!active || (load && is_last));

  // active flag and byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      byte_idx <= '0;
    end else if (pop) begin
      active   <= 1'b1;
      byte_idx <= '0;
    end else if (load) begin
      active   <= !is_last;
      byte_idx <= byte_idx + 1'b1;
    end
  end

  // word left-aligned so the high byte sits at the top
  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= PB'(q_word) << (PB - WORD_BITS);
    end else if (load) begin
      shreg <= shreg << BYTE_BITS;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= shreg[PB-1 -: BYTE_BITS];
      out_last <= is_last;
    end
  end

  // after the last byte of a word the counter starts over
  a_idx_wrap: assert property (@(posedge clk) disable iff (rst)
    (load && is_last) |=> (byte_idx == '0))
    else $error("byte counter did not wrap");

endmodule

`default_nettype wire

// ===== rtl/core/msb_first_bit_packer_core.sv =====
// msb_first_bit_packer_core: top level of the msb-first bit packer
// depends on mbp_pkg, mbp_front, mbp_queue, mbp_back
// the first byte of an emitted word passes the word queue, the shift register and the output register
// throughput: one request per cycle while the word queue is not full; each emitted word holds the
//   byte output for all of its bytes, so full-width requests are paced by the byte output
// the two-entry word queue sets how far the front can run ahead of the byte output
// rst (synchronous) clears accumulator, bit count, queue and output valid
`default_nettype none

module msb_first_bit_packer_core
  import mbp_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  // [31:0] value, [37:32] width, upper bits zero
  input  wire logic [S_TDATA_BITS-1:0] s_tdata,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // [7:0] out_byte
  output logic [BYTE_BITS-1:0]         m_tdata,
  output logic                         m_tlast
);

  q_status_t            q_status;
  logic                 push;
  logic [WORD_BITS-1:0] push_word;
  logic                 pop;
  logic [WORD_BITS-1:0] pop_word;

  // accumulate fields
  mbp_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_value  (s_tdata[VALUE_BITS-1:0]),
    .in_width  (s_tdata[VALUE_BITS +: WIDTH_BITS]),
    .q_status  (q_status),
    .push      (push),
    .push_word (push_word)
  );

  // words waiting for the byte output
  mbp_queue #(.WORD_BITS(WORD_BITS)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .status    (q_status)
  );

  // byte serializer
  mbp_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_word    (pop_word),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for msb_first_bit_packer_core
// depends on mbp_pkg and the rtl of the packer; a table of directed fields, then random ones,
// each byte checked against an in-bench packer model or a typed word, with random idling on both streams
`default_nettype none

module tb_top;
  import mbp_pkg::*;

  localparam int RANDOM_ITEMS  = 300;
  localparam int CALM_ITEMS    = 40;
  localparam int DRAIN_CYCLES  = 16;
  localparam int TIMEOUT_UNITS = 5000000;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHECK_PREDICT,
    CHECK_NONE,
    CHECK_WORD
  } check_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [WIDTH_BITS-1:0] width;
    check_t                check;
    logic [31:0]           word;
  } field_row_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 last;
  } out_byte_t;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [BYTE_BITS-1:0]    m_tdata;
  logic                    m_tlast;

  // model state: pending bits right-aligned, and their count
  logic [63:0]  acc_bits = '0;
  int unsigned  acc_fill = 0;

  out_byte_t    pending_bytes[$];
  out_byte_t    want_byte;
  int           mismatch_count = 0;
  logic         calm = 1'b0;

  // directed fields, walked in order from reset
  field_row_t directed_rows [21] = '{
    '{32'hFFFF_FFFF, 6'd0,  CHECK_NONE,    32'h0},
    '{32'hFFFF_FFFF, 6'd32, CHECK_NONE,    32'h0},
    '{32'h0000_0000, 6'd0,  CHECK_NONE,    32'h0},
    '{32'h1234_5678, 6'd32, CHECK_WORD,    32'hFFFF_FFFF},
    '{32'h0000_0000, 6'd63, CHECK_WORD,    32'h1234_5678},
    '{32'h0000_00A5, 6'd8,  CHECK_WORD,    32'h0000_0000},
    '{32'hFFFF_FFFF, 6'd1,  CHECK_NONE,    32'h0},
    '{32'h0000_0000, 6'd33, CHECK_WORD,    32'hA580_0000},
    '{32'hDEAD_BEEF, 6'd23, CHECK_NONE,    32'h0},
    '{32'h0000_0001, 6'd1,  CHECK_WORD,    32'h002D_BEEF},
    '{32'hCAFE_F00D, 6'd31, CHECK_PREDICT, 32'h0},
    '{32'h0000_003C, 6'd6,  CHECK_PREDICT, 32'h0},
    '{32'h0F0F_0F0F, 6'd27, CHECK_PREDICT, 32'h0},
    '{32'hAAAA_AAAA, 6'd16, CHECK_PREDICT, 32'h0},
    '{32'h5555_5555, 6'd20, CHECK_PREDICT, 32'h0},
    '{32'h8000_0000, 6'd32, CHECK_PREDICT, 32'h0},
    '{32'h7FFF_FFFF, 6'd40, CHECK_PREDICT, 32'h0},
    '{32'h0000_1234, 6'd13, CHECK_PREDICT, 32'h0},
    '{32'h0000_0000, 6'd0,  CHECK_PREDICT, 32'h0},
    '{32'hFFFF_FFFF, 6'd31, CHECK_PREDICT, 32'h0},
    '{32'h0000_0000, 6'd2,  CHECK_PREDICT, 32'h0}
  };

  msb_first_bit_packer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // clock, period 10
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] low_mask(input int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // append one field msb first; returns 1 with the full word when one leaves
  function automatic logic pack_field(input logic [VALUE_BITS-1:0] value,
                                      input logic [WIDTH_BITS-1:0] width,
                                      output logic [31:0] word);
    int unsigned n;
    int unsigned free_bits;
    int unsigned rest;
    logic [63:0] x;
    logic [63:0] topped;
    n = (width > 32) ? 32 : width;
    free_bits = 32 - acc_fill;
    x = {32'd0, value};
    word = '0;
    if (n <= free_bits) begin
      acc_bits = ((acc_bits << n) | (x & low_mask(n))) & low_mask(32);
      acc_fill = acc_fill + n;
      return 1'b0;
    end
    // top up with the leading bits, the rest starts a new word
    rest = n - free_bits;
    topped = ((acc_bits << free_bits) | ((x >> rest) & low_mask(free_bits))) & low_mask(32);
    word = topped[31:0];
    acc_bits = x & low_mask(rest);
    acc_fill = rest;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // one request on the input stream, expectations queued at acceptance
  task automatic send_field(input logic [VALUE_BITS-1:0] value,
                            input logic [WIDTH_BITS-1:0] width,
                            input check_t check, input logic [31:0] typed_word);
    logic [31:0] word;
    logic        emitted;
    s_tdata  <= {{(S_TDATA_BITS - VALUE_BITS - WIDTH_BITS){1'b0}}, width, value};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    emitted = pack_field(value, width, word);
    if (check == CHECK_WORD) begin
      emitted = 1'b1;
      word = typed_word;
    end else if (check == CHECK_NONE) begin
      emitted = 1'b0;
    end
    if (emitted) begin
      for (int k = 0; k < 4; k++) begin
        pending_bytes.push_back('{word[31 - 8*k -: 8], k == 3});
      end
    end
  endtask

  // random gap on the input side
  task automatic idle_sender();
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // stimulus
  initial begin
    logic [VALUE_BITS-1:0] value;
    logic [WIDTH_BITS-1:0] width;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(directed_rows); i++) begin
      send_field(directed_rows[i].value, directed_rows[i].width,
                 directed_rows[i].check, directed_rows[i].word);
      idle_sender();
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      value = $urandom();
      case ($urandom_range(0, 9))
        0: width = 6'd0;
        1: width = 6'd32;
        2: width = 6'($urandom_range(33, 63));
        3: width = 6'(32 - acc_fill);  // fill the word exactly
        default: width = 6'($urandom_range(1, 31));
      endcase
      send_field(value, width, CHECK_PREDICT, 32'h0);
      idle_sender();
    end
    s_tvalid <= 1'b0;

    // drain, then allow for anything late or extra
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // output side backpressure in random bursts
  initial begin
    m_tready <= 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // compare each accepted byte with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch("byte with nothing expected", {24'd0, m_tdata}, 32'h0);
      end else begin
        want_byte = pending_bytes.pop_front();
        if (m_tdata !== want_byte.data)
          report_mismatch("out_byte", {24'd0, m_tdata}, {24'd0, want_byte.data});
        if (m_tlast !== want_byte.last)
          report_mismatch("last_of_run", {31'd0, m_tlast}, {31'd0, want_byte.last});
      end
    end
  end

  // hang guard
  initial begin
    #(TIMEOUT_UNITS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
